// ===== sv/sbfd_pkg.sv =====
// Shared types, constants and the helper function of the serial-bus frame decoder.
package sbfd_pkg;

    localparam int CHANNEL_COUNT = 16;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    localparam int PAYLOAD_LEN = 23;
    localparam int DATA_LEN    = 22;
    localparam int VALUE_W     = 11;

    localparam logic [4:0] POS_IDLE  = 5'd0;
    localparam logic [4:0] POS_LAST  = 5'd23;
    localparam logic [4:0] POS_END   = 5'd24;
    localparam logic [4:0] FLAGS_OFF = 5'd22;
    localparam logic [4:0] DATA_END  = 5'd22;

    localparam int FLAG_LOST_BIT     = 2;
    localparam int FLAG_FAILSAFE_BIT = 3;

    localparam logic [1:0] LINK_OK       = 2'd0;
    localparam logic [1:0] LINK_LOST     = 2'd1;
    localparam logic [1:0] LINK_FAILSAFE = 2'd2;

    typedef struct packed {
        logic       en;
        logic       bank;
        logic [4:0] off;
        logic [7:0] data;
    } wr_req_t;

    typedef struct packed {
        logic       en;
        logic       bank;
        logic [4:0] off;
    } rd_req_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } frame_done_t;

    typedef enum logic [1:0] {
        DR_IDLE,
        DR_FLAGS,
        DR_RUN
    } drain_state_t;

    function automatic logic [1:0] link_code(input logic [7:0] flags);
        logic [1:0] code;
        code = LINK_OK;
        if (flags[FLAG_FAILSAFE_BIT]) begin
            code = LINK_FAILSAFE;
        end else if (flags[FLAG_LOST_BIT]) begin
            code = LINK_LOST;
        end
        return code;
    endfunction

endpackage

// ===== sv/sbfd_store.sv =====
// Two-bank frame store: one write port, one read port with registered read data.
module sbfd_store (
    input  logic              clk,
    input  sbfd_pkg::wr_req_t wr_req,
    input  sbfd_pkg::rd_req_t rd_req,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [0:1][0:sbfd_pkg::PAYLOAD_LEN-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.bank][wr_req.off] <= wr_req.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.en)
        begin
            rd_data_reg <= mem[rd_req.bank][rd_req.off];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sbfd_framer.sv =====
// Byte framer: hunts for the start byte, writes the payload and checks the end byte.
module sbfd_framer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic                  drain_busy,
    output sbfd_pkg::wr_req_t     wr_req,
    output sbfd_pkg::frame_done_t done
);

    logic [4:0] pos_reg, pos_next;
    logic       bank_reg, bank_next;
    logic       accept;

    // The end byte is held back while the previous frame is still being unpacked.
    assign in_stall = (pos_reg == sbfd_pkg::POS_END) && drain_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pos_next   = pos_reg;
        bank_next  = bank_reg;
        done.valid = 1'b0;
        done.bank  = bank_reg;
        if (accept)
        begin
            if (pos_reg == sbfd_pkg::POS_IDLE)
            begin
                if (rx_byte == sbfd_pkg::START_BYTE)
                begin
                    pos_next = 5'd1;
                end
            end
            else if (pos_reg <= sbfd_pkg::POS_LAST)
            begin
                pos_next = pos_reg + 5'd1;
            end
            else
            begin
                pos_next = sbfd_pkg::POS_IDLE;
                if (pos_reg == sbfd_pkg::POS_END && rx_byte == sbfd_pkg::END_BYTE)
                begin
                    done.valid = 1'b1;
                    bank_next  = !bank_reg;
                end
            end
        end
    end

    always_comb
    begin
        wr_req.en   = accept && (pos_reg != sbfd_pkg::POS_IDLE)
                      && (pos_reg <= sbfd_pkg::POS_LAST);
        wr_req.bank = bank_reg;
        wr_req.off  = pos_reg - 5'd1;
        wr_req.data = rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= sbfd_pkg::POS_IDLE;
            bank_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// ===== sv/sbfd_unpack.sv =====
// Channel unpacker: streams a stored frame through a bit accumulator into the output register.
module sbfd_unpack #(
    parameter int ChannelCount = sbfd_pkg::CHANNEL_COUNT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbfd_pkg::frame_done_t done,
    output logic                  busy,
    output sbfd_pkg::rd_req_t     rd_req,
    input  logic [7:0]            rd_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            channel_index,
    output logic [10:0]           channel_value,
    output logic [1:0]            link_status,
    output logic                  frame_last
);

    localparam logic [3:0] LastCh = 4'(ChannelCount - 1);

    sbfd_pkg::drain_state_t state_reg, state_next;

    logic        bank_reg, bank_next;
    logic [4:0]  off_reg, off_next;
    logic        pend_reg, pend_next;
    logic [18:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [3:0]  ch_reg, ch_next;
    logic [1:0]  status_reg, status_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  index_reg, index_next;
    logic [10:0] value_reg, value_next;
    logic [1:0]  link_reg, link_next;
    logic        last_reg, last_next;

    logic        slot_free;
    logic        emit;
    logic        issue;
    logic [4:0]  cnt_after;
    logic [18:0] acc_after;

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == sbfd_pkg::DR_RUN) && (cnt_reg >= 5'd11) && slot_free;
    assign issue     = (state_reg == sbfd_pkg::DR_RUN)
                       && ((cnt_reg + (pend_reg ? 5'd8 : 5'd0)) < 5'd11)
                       && (off_reg < sbfd_pkg::DATA_END);
    assign cnt_after = emit ? (cnt_reg - 5'd11) : cnt_reg;
    assign acc_after = emit ? (acc_reg >> sbfd_pkg::VALUE_W) : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbfd_pkg::DR_IDLE:
            begin
                if (done.valid)
                begin
                    state_next = sbfd_pkg::DR_FLAGS;
                end
            end
            sbfd_pkg::DR_FLAGS:
            begin
                state_next = sbfd_pkg::DR_RUN;
            end
            sbfd_pkg::DR_RUN:
            begin
                if (emit && ch_reg == LastCh)
                begin
                    state_next = sbfd_pkg::DR_IDLE;
                end
            end
            default:
            begin
                state_next = sbfd_pkg::DR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bank_next   = bank_reg;
        off_next    = off_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        ch_next     = ch_reg;
        status_next = status_reg;
        rd_req.en   = 1'b0;
        rd_req.bank = bank_reg;
        rd_req.off  = off_reg;
        unique case (state_reg)
            sbfd_pkg::DR_IDLE:
            begin
                if (done.valid)
                begin
                    rd_req.en   = 1'b1;
                    rd_req.bank = done.bank;
                    rd_req.off  = sbfd_pkg::FLAGS_OFF;
                    bank_next   = done.bank;
                    off_next    = 5'd0;
                    pend_next   = 1'b0;
                    acc_next    = '0;
                    cnt_next    = '0;
                    ch_next     = '0;
                end
            end
            sbfd_pkg::DR_FLAGS:
            begin
                status_next = sbfd_pkg::link_code(rd_data);
                rd_req.en   = 1'b1;
                rd_req.off  = off_reg;
                off_next    = off_reg + 5'd1;
                pend_next   = 1'b1;
            end
            sbfd_pkg::DR_RUN:
            begin
                rd_req.en = issue;
                if (issue)
                begin
                    off_next = off_reg + 5'd1;
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    acc_next = acc_after | (19'(rd_data) << cnt_after);
                    cnt_next = cnt_after + 5'd8;
                end
                else
                begin
                    acc_next = acc_after;
                    cnt_next = cnt_after;
                end
                if (emit)
                begin
                    ch_next = ch_reg + 4'd1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        index_next     = index_reg;
        value_next     = value_reg;
        link_next      = link_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            index_next     = ch_reg;
            value_next     = acc_reg[10:0];
            link_next      = status_reg;
            last_next      = (ch_reg == LastCh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbfd_pkg::DR_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg   <= bank_next;
        off_reg    <= off_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        ch_reg     <= ch_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        link_reg   <= link_next;
        last_reg   <= last_next;
    end

    assign busy          = (state_reg != sbfd_pkg::DR_IDLE);
    assign out_valid     = out_valid_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign link_status   = link_reg;
    assign frame_last    = last_reg;

endmodule

// ===== sv/sbfd_frame_decoder_unit.sv =====
// Top level of the serial-bus frame decoder: framer, two-bank frame store and channel unpacker.
// Received bytes are taken one per request and one per clock cycle while in_stall is
// low. Outside a frame the block waits for the start byte 0x0F; it then writes the 23
// payload bytes (22 bytes of packed channel data and the flags byte) into one bank of a
// two-bank synchronous frame store and checks that the following byte is the end byte
// 0x00. A good end byte hands that bank to the unpacker and switches writing to the other
// bank, so the next frame is received while the results of this one drain; a bad end
// byte drops the frame and the block hunts for a start byte again. The unpacker first
// reads the flags byte, then streams the data bytes through the store's single read port
// into a bit accumulator and emits one 11-bit channel per request, least significant bit
// first, with link status failsafe over lost over ok. The accumulator keeps at most one
// read in flight, so it gains 8 bits per read against 11 bits per result; with 16
// channels the drain ends when the last result is loaded into the output register, and a
// result that out_stall holds back delays it. Only the byte at the end position of the
// following frame waits for that drain: in_stall is raised while that byte is due and
// the unpacker is busy.
module sbus_frame_decoder_unit #(
    parameter int ChannelCount = sbfd_pkg::CHANNEL_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  channel_index,
    output logic [10:0] channel_value,
    output logic [1:0]  link_status,
    output logic        frame_last
);

    sbfd_pkg::wr_req_t     wr_req;
    sbfd_pkg::rd_req_t     rd_req;
    sbfd_pkg::frame_done_t done;
    logic [7:0]            rd_data;
    logic                  drain_busy;

    // Byte framing and the write side of the frame store.
    sbfd_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .drain_busy (drain_busy),
        .wr_req     (wr_req),
        .done       (done)
    );

    // Two banks of 23 bytes; the read data is registered and arrives in the cycle after the read address.
    sbfd_store u_store (
        .clk     (clk),
        .wr_req  (wr_req),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    // Unpacks the completed bank and holds each result in the output register.
    sbfd_unpack #(
        .ChannelCount (ChannelCount)
    ) u_unpack (
        .clk           (clk),
        .rst_n         (rst_n),
        .done          (done),
        .busy          (drain_busy),
        .rd_req        (rd_req),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .link_status   (link_status),
        .frame_last    (frame_last)
    );

endmodule

// ===== verif/sbfd_checker.sv =====
// Checker of the serial-bus frame decoder: predicts channel results and compares them.
module sbfd_checker #(
    parameter int ChannelCount = sbfd_pkg::CHANNEL_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  channel_index,
    input  logic [10:0] channel_value,
    input  logic [1:0]  link_status,
    input  logic        frame_last,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UsedChannels = (ChannelCount < 1) ? 1 :
                                  (ChannelCount > 16) ? 16 : ChannelCount;

    typedef struct packed {
        logic [3:0]  index;
        logic [10:0] value;
        logic [1:0]  status;
        logic        last;
    } channel_result_t;

    logic [4:0]      frame_pos;
    logic [7:0]      payload [sbfd_pkg::PAYLOAD_LEN];
    channel_result_t expected_channels [$];

    task automatic report_mismatch(input string msg);
        fail_count = fail_count + 1;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // A good end byte releases one result per channel, unpacked little-endian.
    task automatic queue_frame_results();
        logic [sbfd_pkg::DATA_LEN*8-1:0] packed_data;
        logic [1:0]                      status;
        channel_result_t                 res;
        for (int i = 0; i < sbfd_pkg::DATA_LEN; i++)
        begin
            packed_data[8*i +: 8] = payload[i];
        end
        if (payload[sbfd_pkg::FLAGS_OFF][sbfd_pkg::FLAG_FAILSAFE_BIT])
        begin
            status = sbfd_pkg::LINK_FAILSAFE;
        end
        else if (payload[sbfd_pkg::FLAGS_OFF][sbfd_pkg::FLAG_LOST_BIT])
        begin
            status = sbfd_pkg::LINK_LOST;
        end
        else
        begin
            status = sbfd_pkg::LINK_OK;
        end
        for (int k = 0; k < UsedChannels; k++)
        begin
            res.index  = 4'(k);
            res.value  = packed_data[sbfd_pkg::VALUE_W*k +: sbfd_pkg::VALUE_W];
            res.status = status;
            res.last   = (k == UsedChannels - 1);
            expected_channels.push_back(res);
        end
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        if (frame_pos == sbfd_pkg::POS_IDLE)
        begin
            if (b == sbfd_pkg::START_BYTE)
            begin
                frame_pos = 5'd1;
            end
        end
        else if (frame_pos <= sbfd_pkg::POS_LAST)
        begin
            payload[frame_pos - 5'd1] = b;
            frame_pos = frame_pos + 5'd1;
        end
        else
        begin
            // End position: the frame closes whatever the byte is.
            frame_pos = sbfd_pkg::POS_IDLE;
            if (b == sbfd_pkg::END_BYTE)
            begin
                queue_frame_results();
            end
        end
    endtask

    task automatic check_result();
        channel_result_t want;
        if (expected_channels.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected: channel %0d value %0d",
                                      channel_index, channel_value));
            return;
        end
        want = expected_channels.pop_front();
        if (channel_index !== want.index)
        begin
            report_mismatch($sformatf("channel_index %0d, expected %0d",
                                      channel_index, want.index));
        end
        if (channel_value !== want.value)
        begin
            report_mismatch($sformatf("channel %0d: channel_value %0d, expected %0d",
                                      want.index, channel_value, want.value));
        end
        if (link_status !== want.status)
        begin
            report_mismatch($sformatf("channel %0d: link_status %0d, expected %0d",
                                      want.index, link_status, want.status));
        end
        if (frame_last !== want.last)
        begin
            report_mismatch($sformatf("channel %0d: frame_last %0b, expected %0b",
                                      want.index, frame_last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos = sbfd_pkg::POS_IDLE;
            expected_channels.delete();
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                check_result();
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                decode_rx_byte(rx_byte);
            end
        end
        pending = expected_channels.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top of the serial-bus frame decoder: stimulus, output stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling for a correct run, even with idling and stalls.
    localparam int CYCLE_LIMIT  = 200000;
    // Margin allowed after the last expected result, in which a stray extra result would show up.
    localparam int DRAIN_CYCLES = 64;
    // Long receiver hold-off, long enough for a second frame's end byte to be held back.
    localparam int HOLD_CYCLES  = 150;

    localparam logic [7:0] FLAGS_NONE     = 8'h00;
    localparam logic [7:0] FLAGS_LOST     = 8'(1 << sbfd_pkg::FLAG_LOST_BIT);
    localparam logic [7:0] FLAGS_FAILSAFE = 8'(1 << sbfd_pkg::FLAG_FAILSAFE_BIT);
    localparam logic [7:0] FLAGS_OTHER    = ~(FLAGS_LOST | FLAGS_FAILSAFE);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [1:0]  link_status;
    logic        frame_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;

    // quiet switches off all random idling for the closing stretch of the run;
    // hold_go starts the single long hold-off on the result side.
    bit quiet = 1'b0;
    bit hold_go = 1'b0;
    bit hold_off = 1'b0;

    always #4 clk = ~clk;

    sbus_frame_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .link_status   (link_status),
        .frame_last    (frame_last)
    );

    sbfd_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .link_status   (link_status),
        .frame_last    (frame_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ERROR: cycle limit of %0d reached, %0d results outstanding",
                     CYCLE_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result-side stalls. The long hold-off wins over everything; otherwise stalls
    // come in random bursts, and stop once the run goes quiet.
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_stall <= 1'b1;
        end
        else if (burst_left != 0)
        begin
            out_stall  <= 1'b1;
            burst_left <= burst_left - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            burst_left <= $urandom_range(0, 9);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // The hold-off is timed in its own process so that the sender carries on
    // offering bytes throughout; the decoder must then fill up and hold back an end byte.
    initial
    begin
        wait (hold_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offers one byte and returns once the request has been accepted. A random gap
    // of idle cycles may come first, so idling can land on any frame position.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Start byte, 22 packed data bytes (lowest byte first), flags byte, closing byte.
    task automatic send_frame(input logic [sbfd_pkg::DATA_LEN*8-1:0] data,
                              input logic [7:0] flags, input logic [7:0] tail);
        send_byte(sbfd_pkg::START_BYTE);
        for (int i = 0; i < sbfd_pkg::DATA_LEN; i++)
        begin
            send_byte(data[8*i +: 8]);
        end
        send_byte(flags);
        send_byte(tail);
    endtask

    function automatic logic [sbfd_pkg::DATA_LEN*8-1:0] random_payload();
        logic [sbfd_pkg::DATA_LEN*8-1:0] d;
        for (int i = 0; i < sbfd_pkg::DATA_LEN; i++)
        begin
            d[8*i +: 8] = 8'($urandom);
        end
        return d;
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle noise: none of these may open a frame.
        send_byte(8'hFF);
        send_byte(sbfd_pkg::END_BYTE);
        send_byte(sbfd_pkg::START_BYTE - 8'd1);
        send_byte(sbfd_pkg::START_BYTE + 8'd1);

        // Every channel at full scale with every flag bit set: failsafe must win.
        send_frame('1, 8'hFF, sbfd_pkg::END_BYTE);
        // Every channel at zero, signal lost, with the unused flag bits set as well.
        send_frame('0, FLAGS_LOST | FLAGS_OTHER, sbfd_pkg::END_BYTE);

        // The long hold-off starts while the last frame drains, so the closing byte
        // of the next frame is held back.
        hold_go <= 1'b1;

        // A bad end byte drops the frame.
        send_frame(random_payload(), FLAGS_FAILSAFE, 8'h80);

        // A bad end byte equal to the start byte drops the frame and must not open a
        // new one. Had it opened one, the flags byte of the frame after it would sit at
        // the end position and close that stray frame as a good one.
        send_frame(random_payload(), FLAGS_LOST, sbfd_pkg::START_BYTE);

        // The closing stretch runs without idling on either side.
        quiet <= 1'b1;
        send_frame({11{8'hA5, 8'h5A}}, FLAGS_NONE, sbfd_pkg::END_BYTE);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // Let any stray extra result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
